// ===== sv/look_at_view_matrix_top_defines.svh =====
// Assertion macros for the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_DEFINES_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define LAV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define LAV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/lav_pkg.sv =====
// Shared types and constants of the look-at view matrix block.
package lav_pkg;
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_DIVLD,
		ST_DIV,
		ST_MAC,
		ST_EMIT
	} lav_state_t;

	typedef enum logic [1:0] {
		GRP_CROSS,
		GRP_UP,
		GRP_DOT
	} lav_grp_t;

	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][31:0] tgt;
		logic [2:0][31:0] uph;
		logic             zero_fwd;
	} lav_item_t;

	typedef struct packed {
		logic valid;
		logic full;
	} lav_stat_t;

	localparam int NORM_HI_BIT = 30;
	localparam int NORM_LO_BIT = 29;
	localparam int SQRT_TOP_K = 30;
endpackage

// ===== sv/lav_front.sv =====
// Front end: accepts a command beat and flags a zero-length forward vector.
module lav_front import lav_pkg::*; (
	input  logic             start,
	input  logic [31:0]      eye_x,
	input  logic [31:0]      eye_y,
	input  logic [31:0]      eye_z,
	input  logic [31:0]      target_x,
	input  logic [31:0]      target_y,
	input  logic [31:0]      target_z,
	input  logic [31:0]      up_hint_x,
	input  logic [31:0]      up_hint_y,
	input  logic [31:0]      up_hint_z,
	input  lav_stat_t        q_stat,
	output logic             busy,
	output logic             push,
	output lav_item_t        item
);
	assign busy = q_stat.full;
	assign push = start & ~q_stat.full;

	always_comb begin
		item.eye = {eye_z, eye_y, eye_x};
		item.tgt = {target_z, target_y, target_x};
		item.uph = {up_hint_z, up_hint_y, up_hint_x};
		item.zero_fwd = (eye_x == target_x) && (eye_y == target_y) && (eye_z == target_z);
	end
endmodule

// ===== sv/lav_fifo.sv =====
// Two-entry queue between front end and back end.
module lav_fifo import lav_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lav_item_t wr_item,
	input  logic      pop,
	output lav_item_t rd_item,
	output lav_stat_t stat
);
	lav_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	assign rd_item = mem_q[rd_ptr_q];
	assign stat.valid = (count_q != 2'd0);
	assign stat.full = (count_q == 2'd2);
endmodule

// ===== sv/lav_back.sv =====
// Back end: normalize, cross products, dot products and column output.
module lav_back import lav_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lav_stat_t          q_stat,
	input  lav_item_t          q_item,
	output logic               pop,
	output logic               done,
	output logic [1:0]         column_index,
	output logic signed [31:0] entry_row0,
	output logic signed [31:0] entry_row1,
	output logic signed [31:0] entry_row2,
	output logic signed [31:0] entry_row3,
	output logic               degenerate,
	output logic               last_column
);
	localparam int UNW = FRAC_BITS + 3;
	localparam int VW  = FRAC_BITS + 34;
	localparam int PW  = UNW + 32;
	localparam int AW  = FRAC_BITS + 36;
	localparam int QW  = FRAC_BITS + 2;
	localparam int DW  = FRAC_BITS + 31;
	localparam int CW  = 6;
	localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;
	localparam logic [AW-1:0] HALF_LSB = AW'(1) << (FRAC_BITS - 1);

	lav_state_t state_q, state_d;
	lav_grp_t   grp_q;
	logic       phase_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] k_q, t_q, col_q;
	logic       ph_q;
	logic       degen_q;

	logic signed [31:0]    eye_q [3];
	logic signed [31:0]    uph_q [3];
	logic signed [VW-1:0]  vec_q [3];
	logic [VW-1:0]         mag_q [3];
	logic signed [UNW-1:0] f_q [3];
	logic signed [UNW-1:0] s_q [3];
	logic signed [UNW-1:0] u_q [3];
	logic signed [31:0]    col3_q [3];
	logic [59:0]           sq_prod_q;
	logic [63:0]           x_q, res_q;
	logic [32:0]           rem_q;
	logic [QW-1:0]         dlow_q, quo_q;
	logic signed [PW-1:0]  prod_q;
	logic                  sub_q;
	logic signed [AW-1:0]  acc_q;

	function automatic logic signed [AW-1:0] shr_round(input logic signed [AW-1:0] v);
		logic [AW-1:0] m;
		logic [AW-1:0] r;
		m = v[AW-1] ? AW'(-v) : AW'(v);
		r = (m + HALF_LSB) >> FRAC_BITS;
		return v[AW-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
		if (v > $signed(AW'(32'sh7fffffff))) return 32'sh7fffffff;
		if (v < -$signed(AW'(33'sh080000000))) return 32'sh80000000;
		return v[31:0];
	endfunction

	// normalize window tests across the three magnitudes
	logic all_zero, any_hi, any_mid;
	always_comb begin
		all_zero = 1'b1;
		any_hi = 1'b0;
		any_mid = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (mag_q[i] != '0) all_zero = 1'b0;
			if ((mag_q[i] >> NORM_HI_BIT) != '0) any_hi = 1'b1;
			if ((mag_q[i] >> NORM_LO_BIT) != '0) any_mid = 1'b1;
		end
	end

	// square-root step
	logic [63:0] sq_bit, sq_try;
	assign sq_bit = 64'(1) << {cnt_q, 1'b0};
	assign sq_try = res_q + sq_bit;

	// divider step
	logic [31:0]   len;
	logic [DW-1:0] div_d;
	logic [32:0]   rem2;
	logic          qbit;
	logic [QW-1:0] quo_n;
	logic signed [UNW-1:0] qv, unit_v;
	assign len = res_q[31:0];
	assign div_d = (DW'(mag_q[k_q][29:0]) << FRAC_BITS) + DW'(res_q[31:1]);
	assign rem2 = {rem_q[31:0], dlow_q[QW-1]};
	assign qbit = (rem2 >= {1'b0, len});
	assign quo_n = {quo_q[QW-2:0], qbit};
	assign qv = $signed(UNW'(quo_n));
	assign unit_v = vec_q[k_q][VW-1] ? -qv : qv;

	// multiply-accumulate operand select
	logic [1:0] i1, i2, t_last;
	logic signed [UNW-1:0] a_mul;
	logic signed [31:0]    b_mul;
	logic                  sub_n;
	logic signed [AW-1:0]  acc_n, dot_r;
	always_comb begin
		case (k_q)
			2'd0: begin i1 = 2'd1; i2 = 2'd2; end
			2'd1: begin i1 = 2'd2; i2 = 2'd0; end
			default: begin i1 = 2'd0; i2 = 2'd1; end
		endcase
		a_mul = '0;
		b_mul = '0;
		sub_n = (t_q != 2'd0);
		t_last = 2'd1;
		case (grp_q)
			GRP_CROSS: begin
				a_mul = (t_q == 2'd0) ? f_q[i1] : f_q[i2];
				b_mul = (t_q == 2'd0) ? uph_q[i2] : uph_q[i1];
			end
			GRP_UP: begin
				a_mul = (t_q == 2'd0) ? s_q[i1] : s_q[i2];
				b_mul = (t_q == 2'd0) ? 32'(f_q[i2]) : 32'(f_q[i1]);
			end
			default: begin
				sub_n = 1'b0;
				t_last = 2'd2;
				case (k_q)
					2'd0: a_mul = s_q[t_q];
					2'd1: a_mul = u_q[t_q];
					default: a_mul = f_q[t_q];
				endcase
				b_mul = eye_q[t_q];
			end
		endcase
	end
	assign acc_n = ((t_q == 2'd0) ? AW'(0) : acc_q) + (sub_q ? -AW'(prod_q) : AW'(prod_q));
	assign dot_r = shr_round(acc_n);

	// next state
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_stat.valid) begin
					pop = 1'b1;
					state_d = q_item.zero_fwd ? ST_EMIT : ST_MAG;
				end
			end
			ST_MAG: state_d = ST_NORM;
			ST_NORM: begin
				if (all_zero) state_d = ST_EMIT;
				else if (!any_hi && any_mid) state_d = ST_SQ;
			end
			ST_SQ: if (cnt_q == CW'(3)) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == '0) state_d = ST_DIVLD;
			ST_DIVLD: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CW'(QW - 1)) state_d = (k_q == 2'd2) ? ST_MAC : ST_DIVLD;
			end
			ST_MAC: begin
				if (ph_q && t_q == t_last && k_q == 2'd2) begin
					case (grp_q)
						GRP_CROSS: state_d = ST_MAG;
						GRP_UP: state_d = ST_MAC;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_EMIT: if (col_q == 2'd3) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					eye_q[i] <= q_item.eye[i];
					uph_q[i] <= q_item.uph[i];
					vec_q[i] <= VW'($signed(q_item.tgt[i])) - VW'($signed(q_item.eye[i]));
				end
				degen_q <= q_item.zero_fwd;
				phase_q <= 1'b0;
				col_q <= 2'd0;
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++)
					mag_q[i] <= vec_q[i][VW-1] ? VW'(-vec_q[i]) : VW'(vec_q[i]);
			end
			ST_NORM: begin
				if (all_zero) begin
					degen_q <= 1'b1;
					col_q <= 2'd0;
				end else if (any_hi) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (!any_mid) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end else begin
					cnt_q <= '0;
					x_q <= '0;
				end
			end
			ST_SQ: begin
				if (cnt_q != CW'(3))
					sq_prod_q <= mag_q[cnt_q[1:0]][29:0] * mag_q[cnt_q[1:0]][29:0];
				if (cnt_q != '0) x_q <= x_q + 64'(sq_prod_q);
				if (cnt_q == CW'(3)) begin
					res_q <= '0;
					cnt_q <= CW'(SQRT_TOP_K);
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			ST_SQRT: begin
				if (x_q >= sq_try) begin
					x_q <= x_q - sq_try;
					res_q <= (res_q >> 1) + sq_bit;
				end else begin
					res_q <= res_q >> 1;
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) k_q <= 2'd0;
			end
			ST_DIVLD: begin
				rem_q <= 33'(div_d >> QW);
				dlow_q <= div_d[QW-1:0];
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= qbit ? rem2 - {1'b0, len} : rem2;
				quo_q <= quo_n;
				dlow_q <= dlow_q << 1;
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					if (phase_q) s_q[k_q] <= unit_v;
					else f_q[k_q] <= unit_v;
					if (k_q == 2'd2) begin
						k_q <= 2'd0;
						t_q <= 2'd0;
						ph_q <= 1'b0;
						grp_q <= phase_q ? GRP_UP : GRP_CROSS;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
			end
			ST_MAC: begin
				if (!ph_q) begin
					prod_q <= a_mul * b_mul;
					sub_q <= sub_n;
					ph_q <= 1'b1;
				end else begin
					ph_q <= 1'b0;
					if (t_q == t_last) begin
						case (grp_q)
							GRP_CROSS: vec_q[k_q] <= acc_n[VW-1:0];
							GRP_UP: u_q[k_q] <= dot_r[UNW-1:0];
							default: col3_q[k_q] <= sat32((k_q == 2'd2) ? dot_r : -dot_r);
						endcase
						t_q <= 2'd0;
						if (k_q == 2'd2) begin
							k_q <= 2'd0;
							case (grp_q)
								GRP_CROSS: phase_q <= 1'b1;
								GRP_UP: grp_q <= GRP_DOT;
								default: col_q <= 2'd0;
							endcase
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						acc_q <= acc_n;
						t_q <= t_q + 2'd1;
					end
				end
			end
			ST_EMIT: col_q <= col_q + 2'd1;
			default: ;
		endcase
	end

	// column assembly
	logic [1:0] cc;
	logic signed [31:0] row [4];
	assign cc = (col_q == 2'd3) ? 2'd0 : col_q;
	always_comb begin
		for (int r = 0; r < 4; r++) row[r] = '0;
		if (degen_q) begin
			for (int r = 0; r < 4; r++) row[r] = (col_q == 2'(r)) ? ONE_FX : 32'd0;
		end else if (col_q == 2'd3) begin
			row[0] = col3_q[0];
			row[1] = col3_q[1];
			row[2] = col3_q[2];
			row[3] = ONE_FX;
		end else begin
			row[0] = 32'(s_q[cc]);
			row[1] = 32'(u_q[cc]);
			row[2] = 32'(-f_q[cc]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= (state_q == ST_EMIT);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			column_index <= col_q;
			entry_row0 <= row[0];
			entry_row1 <= row[1];
			entry_row2 <= row[2];
			entry_row3 <= row[3];
			degenerate <= degen_q;
			last_column <= (col_q == 2'd3);
		end
	end
endmodule

// ===== sv/look_at_view_matrix_top.sv =====
// Right-handed look-at view matrix builder, top level.
// A beat is taken when start is high and busy is low; up to two beats wait in a queue
// while the back end works. Each item yields four column beats on consecutive cycles,
// each flagged by done for one cycle, which the receiver must take as they come.
// The time one item occupies the back end grows with Nf and Nr, the counts of one-bit
// shifts that bring the forward and right vectors into range; the single shared shift,
// square-root and restoring-divide sequencer sets that time.
// A target equal to the eye point skips the arithmetic: the back end goes straight from
// taking the beat to emitting the four identity columns.
`include "look_at_view_matrix_top_defines.svh"
module look_at_view_matrix_top import lav_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        eye_x,
	input  logic [31:0]        eye_y,
	input  logic [31:0]        eye_z,
	input  logic [31:0]        target_x,
	input  logic [31:0]        target_y,
	input  logic [31:0]        target_z,
	input  logic [31:0]        up_hint_x,
	input  logic [31:0]        up_hint_y,
	input  logic [31:0]        up_hint_z,
	output logic               done,
	output logic [1:0]         column_index,
	output logic signed [31:0] entry_row0,
	output logic signed [31:0] entry_row1,
	output logic signed [31:0] entry_row2,
	output logic signed [31:0] entry_row3,
	output logic               degenerate,
	output logic               last_column
);
	lav_stat_t q_stat;
	lav_item_t wr_item, rd_item;
	logic      push, pop;

	lav_front u_front (
		.start(start), .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.up_hint_x(up_hint_x), .up_hint_y(up_hint_y), .up_hint_z(up_hint_z),
		.q_stat(q_stat), .busy(busy), .push(push), .item(wr_item)
	);

	lav_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_item(wr_item),
		.pop(pop), .rd_item(rd_item), .stat(q_stat)
	);

	lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_stat(q_stat), .q_item(rd_item), .pop(pop),
		.done(done), .column_index(column_index),
		.entry_row0(entry_row0), .entry_row1(entry_row1),
		.entry_row2(entry_row2), .entry_row3(entry_row3),
		.degenerate(degenerate), .last_column(last_column)
	);

	`LAV_ASSERT_NEXT(a_cols_back_to_back, done && !last_column, done, "column beats broke up")
	`LAV_ASSERT_NEXT(a_gap_after_last, done && last_column, !done, "beat right after last column")
	`LAV_ASSERT_SAME(a_last_is_col3, done, last_column == (column_index == 2'd3), "last flag off")
	`LAV_ASSERT_NEXT(a_col_order, done && !last_column, column_index == $past(column_index) + 2'd1, "column order")
endmodule

// ===== tb/lav_checker.sv =====
// Checker for the look-at view matrix block: predicts each column beat and compares.
module lav_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] eye_x,
	input  logic [31:0] eye_y,
	input  logic [31:0] eye_z,
	input  logic [31:0] target_x,
	input  logic [31:0] target_y,
	input  logic [31:0] target_z,
	input  logic [31:0] up_hint_x,
	input  logic [31:0] up_hint_y,
	input  logic [31:0] up_hint_z,
	input  logic        done,
	input  logic [1:0]  column_index,
	input  logic [31:0] entry_row0,
	input  logic [31:0] entry_row1,
	input  logic [31:0] entry_row2,
	input  logic [31:0] entry_row3,
	input  logic        degenerate,
	input  logic        last_column,
	output int          errors,
	output int          pending,
	output int          columns_seen,
	output int          degen_seen
);
	typedef struct {
		logic [1:0]  col;
		logic [31:0] row [4];
		logic        degen;
		logic        last;
	} column_t;

	column_t columns_due [$];

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint round_shift(input longint v);
		logic [63:0] m;
		m = (magnitude(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// block-scale into [2^29, 2^30), then divide by floor length with round-half-up
	function automatic bit to_unit(input longint v [3], output longint u [3]);
		logic [63:0] m [3];
		logic [63:0] top, sum, len, q;
		top = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magnitude(v[i]);
			if (m[i] > top) top = m[i];
		end
		if (top == 0) return 0;
		while (top >= (64'd1 << 30)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (top < (64'd1 << 29)) begin
			top <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += m[i] * m[i];
		len = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC_BITS) + len / 2) / len;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint eye_dot(input longint a [3], input longint e [3]);
		return round_shift(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
	endfunction

	task automatic predict_view(input logic [31:0] ein [3], input logic [31:0] tin [3],
			input logic [31:0] hin [3]);
		longint e [3], t [3], h [3], fr [3], f [3], rr [3], s [3], u [3];
		longint mat [4][4];
		bit degen;
		column_t c;
		degen = 0;
		for (int i = 0; i < 3; i++) begin
			e[i] = longint'(signed'(ein[i]));
			t[i] = longint'(signed'(tin[i]));
			h[i] = longint'(signed'(hin[i]));
			fr[i] = t[i] - e[i];
		end
		if (!to_unit(fr, f)) begin
			degen = 1;
		end else begin
			rr[0] = f[1] * h[2] - f[2] * h[1];
			rr[1] = f[2] * h[0] - f[0] * h[2];
			rr[2] = f[0] * h[1] - f[1] * h[0];
			if (!to_unit(rr, s)) degen = 1;
		end
		if (degen) begin
			for (int ci = 0; ci < 4; ci++)
				for (int r = 0; r < 4; r++)
					mat[ci][r] = (ci == r) ? (64'sd1 << FRAC_BITS) : 0;
		end else begin
			u[0] = round_shift(s[1] * f[2] - s[2] * f[1]);
			u[1] = round_shift(s[2] * f[0] - s[0] * f[2]);
			u[2] = round_shift(s[0] * f[1] - s[1] * f[0]);
			for (int ci = 0; ci < 3; ci++) begin
				mat[ci][0] = s[ci];
				mat[ci][1] = u[ci];
				mat[ci][2] = -f[ci];
				mat[ci][3] = 0;
			end
			mat[3][0] = -eye_dot(s, e);
			mat[3][1] = -eye_dot(u, e);
			mat[3][2] = eye_dot(f, e);
			mat[3][3] = 64'sd1 << FRAC_BITS;
		end
		for (int ci = 0; ci < 4; ci++) begin
			c.col = 2'(ci);
			for (int r = 0; r < 4; r++) c.row[r] = clamp32(mat[ci][r]);
			c.degen = degen;
			c.last = (ci == 3);
			columns_due.push_back(c);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		column_t c;
		if (arst_n) begin
			if (start && !busy)
				predict_view('{eye_x, eye_y, eye_z}, '{target_x, target_y, target_z},
					'{up_hint_x, up_hint_y, up_hint_z});
			if (done) begin
				columns_seen++;
				if (columns_due.size() == 0) begin
					errors++;
					$display("%0t: column beat with nothing expected, column %0d",
						$time, column_index);
				end else begin
					c = columns_due.pop_front();
					if (c.degen) degen_seen++;
					check_field("column_index", 32'(c.col), 32'(column_index));
					check_field("entry_row0", c.row[0], entry_row0);
					check_field("entry_row1", c.row[1], entry_row1);
					check_field("entry_row2", c.row[2], entry_row2);
					check_field("entry_row3", c.row[3], entry_row3);
					check_field("degenerate", 32'(c.degen), 32'(degenerate));
					check_field("last_column", 32'(c.last), 32'(last_column));
				end
			end
		end
		pending <= columns_due.size();
	end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the look-at view matrix block: stimulus, timeout and verdict.
module tb;
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] eye_x, eye_y, eye_z;
	logic [31:0] target_x, target_y, target_z;
	logic [31:0] up_hint_x, up_hint_y, up_hint_z;
	logic        done;
	logic [1:0]  column_index;
	logic signed [31:0] entry_row0, entry_row1, entry_row2, entry_row3;
	logic        degenerate;
	logic        last_column;
	int          errors, pending, columns_seen, degen_seen;
	int          views_sent;
	int          cycle_count;

	localparam int ONE = 32'h0001_0000;
	localparam int CYCLE_LIMIT = 1000000;

	look_at_view_matrix_top #(.FRAC_BITS(16)) u_dut (.*);

	lav_checker #(.FRAC_BITS(16)) u_checker (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d columns outstanding", cycle_count, pending);
			$display("tb: errors");
			$finish;
		end
	end

	// start stays high between back-to-back beats; it is lowered by pause() and before each drain wait
	task automatic send_view(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
		eye_x <= ex; eye_y <= ey; eye_z <= ez;
		target_x <= tx; target_y <= ty; target_z <= tz;
		up_hint_x <= ux; up_hint_y <= uy; up_hint_z <= uz;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		views_sent++;
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord(input int shape);
		case (shape)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * 200 * ONE)) - 200 * ONE);
			2: return 32'($signed($urandom_range(0, 16 * ONE)) - 8 * ONE);
			default: return 32'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	initial begin
		logic [31:0] e [3], t [3], h [3];
		int k, shape;
		views_sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{eye_x, eye_y, eye_z, target_x, target_y, target_z} = '0;
		{up_hint_x, up_hint_y, up_hint_z} = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain camera, then target at the eye, zero up, up parallel to forward
		send_view(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
		send_view(3 * ONE, -2 * ONE, ONE, 3 * ONE, -2 * ONE, ONE, 0, ONE, 0);
		send_view(0, 0, 0, ONE, 2 * ONE, 3 * ONE, 0, 0, 0);
		send_view(0, 0, 0, 0, 4 * ONE, 0, 0, 7 * ONE, 0);
		send_view(ONE, ONE, ONE, 0, 0, 0, -2 * ONE, -2 * ONE, -2 * ONE);
		// extremes of the fields; translation column saturates
		send_view(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff);
		send_view(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 1,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0,
			0, 32'h8000_0000, 1);
		send_view(0, 0, 0, 1, 0, 0, 0, 1, 0);
		send_view(0, 0, 0, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
		send_view(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 1, 0, 32'h7fff_ffff, 0, 0);
		send_view(10 * ONE, 0, 0, 0, 0, 0, 0, 0, ONE);
		send_view(0, 10 * ONE, 0, 0, 0, 0, 0, 0, -ONE);
		pause(3);

		for (int i = 0; i < 200; i++) begin
			shape = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 3);
			for (int j = 0; j < 3; j++) begin
				e[j] = pick_coord(shape);
				t[j] = pick_coord(shape);
				h[j] = pick_coord($urandom_range(0, 3));
			end
			case ($urandom_range(0, 19))
				0: t = e;
				1: h = '{0, 0, 0};
				2: begin
					k = $urandom_range(1, 4);
					for (int j = 0; j < 3; j++) h[j] = (t[j] - e[j]) * k;
				end
				default: ;
			endcase
			send_view(e[0], e[1], e[2], t[0], t[1], t[2], h[0], h[1], h[2]);
			if (i == 100) begin
				// drain everything before going on
				start <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end else if (i < 170 && $urandom_range(0, 3) == 0) begin
				pause($urandom_range(1, 15));
			end
		end
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("%0d views sent, %0d column beats checked, %0d of them degenerate",
			views_sent, columns_seen, degen_seen);
		if (errors == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/lav_pkg.sv
sv/lav_front.sv
sv/lav_fifo.sv
sv/lav_back.sv
sv/look_at_view_matrix_top.sv
tb/lav_checker.sv
tb/tb.sv
